// ===== hw/rtl/lmlf_pkg.sv =====
package lmlf_pkg;

	localparam int MAX_MARGIN    = 4;
	localparam int NUM_BOUNDS    = 4;
	localparam int MARGIN_CAP    = (MAX_MARGIN < NUM_BOUNDS) ? MAX_MARGIN : NUM_BOUNDS;
	localparam int COS_FRAC_BITS = 15;
	localparam int LOGIT_W       = 48;

	typedef enum logic [2:0] {
		REG_MARGIN = 3'd0,
		REG_BLEND  = 3'd1,
		REG_BOUND1 = 3'd2,
		REG_BOUND2 = 3'd3,
		REG_BOUND3 = 3'd4,
		REG_BOUND4 = 3'd5,
		REG_BINOM2 = 3'd6,
		REG_BINOM4 = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]                  margin;
		logic [31:0]                 blend;
		logic [NUM_BOUNDS-1:0][15:0] bound;
		logic [7:0]                  binom2;
		logic [7:0]                  binom4;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] dot;
		logic [63:0]        prod;
		logic               degen;
	} smp_t;

	typedef struct packed {
		logic signed [31:0] dot;
		logic [2:0]         k;
		logic signed [16:0] cm;
		logic               degen;
	} tag_t;

	function automatic logic [2:0] eff_margin(logic [2:0] mv);
		logic [2:0] m;
		m = (mv == 3'd0) ? 3'd1 : mv;
		if (m > 3'(MARGIN_CAP)) begin
			m = 3'(MARGIN_CAP);
		end
		return m;
	endfunction

endpackage

// ===== hw/rtl/lmlf_cos_div.sv =====
module lmlf_cos_div
	import lmlf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  smp_t               in_smp,
	output logic               out_vld,
	output smp_t               out_smp,
	output logic signed [16:0] out_cos
);

	localparam int STEPS = COS_FRAC_BITS;

	logic [STEPS:0]   vld_s;
	logic [63:0]      rem_s [STEPS+1];
	logic [STEPS-1:0] quo_s [STEPS+1];
	logic             neg_s [STEPS+1];
	logic             ovf_s [STEPS+1];
	smp_t             smp_s [STEPS+1];

	logic [31:0] dmag;
	logic        ovf;
	logic [64:0] dbl  [1:STEPS];
	logic [64:0] diff [1:STEPS];
	logic [15:0] mag16;
	logic [16:0] mag17;

	always_comb begin
		dmag = in_smp.dot[31] ? 32'(-in_smp.dot) : 32'(in_smp.dot);
		ovf  = {16'd0, dmag, 16'd0} >= in_smp.prod;
		for (int i = 1; i <= STEPS; i++) begin
			dbl[i]  = {rem_s[i-1], 1'b0};
			diff[i] = dbl[i] - {1'b0, smp_s[i-1].prod};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[STEPS-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ovf ? 64'd0 : {16'd0, dmag, 16'd0};
			quo_s[0] <= '0;
			neg_s[0] <= in_smp.dot[31];
			ovf_s[0] <= ovf;
			smp_s[0] <= in_smp;
			for (int i = 1; i <= STEPS; i++) begin
				rem_s[i] <= diff[i][64] ? dbl[i][63:0] : diff[i][63:0];
				quo_s[i] <= {quo_s[i-1][STEPS-2:0], !diff[i][64]};
				neg_s[i] <= neg_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
				smp_s[i] <= smp_s[i-1];
			end
		end
	end

	always_comb begin
		mag16   = ovf_s[STEPS] ? 16'h8000 : {1'b0, quo_s[STEPS]};
		mag17   = {1'b0, mag16};
		out_cos = neg_s[STEPS] ? $signed(-mag17) : $signed(mag17);
	end

	assign out_vld = vld_s[STEPS];
	assign out_smp = smp_s[STEPS];

endmodule

// ===== hw/rtl/lmlf_cos_mult.sv =====
module lmlf_cos_mult
	import lmlf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cfg_t               cfg,
	input  logic               in_vld,
	input  smp_t               in_smp,
	input  logic signed [16:0] in_cos,
	output logic               out_vld,
	output smp_t               out_smp,
	output logic [2:0]         out_k,
	output logic signed [16:0] out_cm,
	output logic signed [19:0] out_g
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	smp_t smp_s1, smp_s2, smp_s3, smp_s4, smp_s5, smp_s6;
	logic [2:0] k_s1, k_s2, k_s3, k_s4, k_s5, k_s6;
	logic [2:0] m_s1, m_s2, m_s3;

	logic signed [16:0] c_s1, c_s2, c_s3;
	logic [30:0]        csq_s1, csq_s2, csq_s3;
	logic signed [31:0] cp3_s2, cp3_s3, cp4_s3, a3_s3;
	logic [30:0]        s2_s2, s2_s3, s2sq_s3, a4_s3;
	logic signed [31:0] t0_s4;
	logic signed [40:0] t1_s4;
	logic [38:0]        t2_s4;
	logic signed [16:0] cm_s5, cm_s6;
	logic signed [19:0] g_s6;

	logic [2:0]         k;
	logic [2:0]         m;
	logic signed [33:0] csq_full;
	logic signed [48:0] p3, r3, p4, r4, pa3, ra3;
	logic [61:0]        sq, sqr, pa4, pa4r;
	logic signed [31:0] t0, b1;
	logic signed [42:0] sum, rs;
	logic signed [16:0] cm;
	logic signed [19:0] cm20;

	always_comb begin
		m        = eff_margin(cfg.margin);
		csq_full = in_cos * in_cos;
		k        = 3'd0;
		for (int i = 1; i <= NUM_BOUNDS; i++) begin
			if (3'(i) <= m && in_cos < 17'($signed(cfg.bound[i-1]))) begin
				k = 3'(i);
			end
		end
	end

	always_comb begin
		p3   = $signed({1'b0, csq_s1}) * c_s1;
		r3   = (p3 + 49'sd16384) >>> 15;
		p4   = cp3_s2 * c_s2;
		r4   = (p4 + 49'sd16384) >>> 15;
		pa3  = c_s2 * $signed({1'b0, s2_s2});
		ra3  = (pa3 + 49'sd16384) >>> 15;
		sq   = s2_s2 * s2_s2;
		sqr  = sq + (62'd1 << 29);
		pa4  = csq_s2 * s2_s2;
		pa4r = pa4 + (62'd1 << 29);
	end

	always_comb begin
		unique case (m_s3)
			3'd1: begin
				t0 = $signed({c_s3, 15'd0});
				b1 = 32'sd0;
			end
			3'd2: begin
				t0 = $signed({1'b0, csq_s3});
				b1 = $signed({1'b0, s2_s3});
			end
			3'd3: begin
				t0 = cp3_s3;
				b1 = a3_s3;
			end
			default: begin
				t0 = cp4_s3;
				b1 = $signed({1'b0, a4_s3});
			end
		endcase
	end

	always_comb begin
		sum = 43'(t0_s4) - 43'(t1_s4) + $signed({4'd0, t2_s4});
		rs  = (sum + 43'sd16384) >>> 15;
		if (rs > 43'sd32768) begin
			cm = 17'sd32768;
		end else if (rs < -43'sd32768) begin
			cm = -17'sd32768;
		end else begin
			cm = rs[16:0];
		end
		cm20 = 20'(cm_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1  <= in_smp;
			k_s1    <= k;
			m_s1    <= m;
			c_s1    <= in_cos;
			csq_s1  <= csq_full[30:0];

			smp_s2  <= smp_s1;
			k_s2    <= k_s1;
			m_s2    <= m_s1;
			c_s2    <= c_s1;
			csq_s2  <= csq_s1;
			cp3_s2  <= r3[31:0];
			s2_s2   <= 31'h4000_0000 - csq_s1;

			smp_s3  <= smp_s2;
			k_s3    <= k_s2;
			m_s3    <= m_s2;
			c_s3    <= c_s2;
			csq_s3  <= csq_s2;
			cp3_s3  <= cp3_s2;
			s2_s3   <= s2_s2;
			cp4_s3  <= r4[31:0];
			a3_s3   <= ra3[31:0];
			s2sq_s3 <= sqr[60:30];
			a4_s3   <= pa4r[60:30];

			smp_s4  <= smp_s3;
			k_s4    <= k_s3;
			t0_s4   <= t0;
			t1_s4   <= $signed({1'b0, cfg.binom2}) * b1;
			t2_s4   <= (m_s3 == 3'd4) ? cfg.binom4 * s2sq_s3 : 39'd0;

			smp_s5  <= smp_s4;
			k_s5    <= k_s4;
			cm_s5   <= cm;

			smp_s6  <= smp_s5;
			k_s6    <= k_s5;
			cm_s6   <= cm_s5;
			g_s6    <= (k_s5[0] ? -cm20 : cm20) - $signed({1'b0, k_s5, 16'd0});
		end
	end

	assign out_vld = vld_s6;
	assign out_smp = smp_s6;
	assign out_k   = k_s6;
	assign out_cm  = cm_s6;
	assign out_g   = g_s6;

endmodule

// ===== hw/rtl/lmlf_logit_div.sv =====
module lmlf_logit_div
	import lmlf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [31:0]               blend,
	input  logic                      in_vld,
	input  smp_t                      in_smp,
	input  logic [2:0]                in_k,
	input  logic signed [16:0]        in_cm,
	input  logic signed [19:0]        in_g,
	output logic                      out_vld,
	output logic signed [LOGIT_W-1:0] out_logit,
	output logic [2:0]                out_k,
	output logic signed [16:0]        out_cm,
	output logic                      out_degen
);

	localparam int QB = LOGIT_W;

	logic vld_s1, vld_s2, vld_s3, vld_s5;
	tag_t tag_s1, tag_s2, tag_s3;
	logic signed [52:0] gl_s1, gh_s1;
	logic [63:0]        ld_s1;
	logic               dneg_s1;
	logic [32:0]        lamp_s1, lamp_s2, lamp_s3;
	logic signed [86:0] num_s2;
	logic               neg_s3;
	logic [85:0]        mag_s3;

	logic [QB:0]   vld_sd;
	logic [QB-1:0] rem_sd [QB+1];
	logic [QB-1:0] low_sd [QB+1];
	logic [QB-1:0] quo_sd [QB+1];
	logic [QB-1:0] den_sd [QB+1];
	logic          neg_sd [QB+1];
	logic          ovf_sd [QB+1];
	tag_t          tag_sd [QB+1];

	logic signed [LOGIT_W-1:0] logit_s5;
	logic [2:0]                k_s5;
	logic signed [16:0]        cm_s5;
	logic                      degen_s5;

	logic [31:0]        dmag;
	tag_t               tag_in;
	logic signed [86:0] ghx, glx, ldx, num;
	logic [86:0]        nneg;
	logic [85:0]        nd;
	logic               ovf;
	logic [QB:0]        dbl  [1:QB];
	logic [QB+1:0]      diff [1:QB];
	logic [QB-1:0]      limit, qmag, res;

	always_comb begin
		dmag         = in_smp.dot[31] ? 32'(-in_smp.dot) : 32'(in_smp.dot);
		tag_in.dot   = in_smp.dot;
		tag_in.k     = in_k;
		tag_in.cm    = in_cm;
		tag_in.degen = in_smp.degen;

		ghx = 87'(gh_s1) <<< 32;
		glx = 87'(gl_s1);
		ldx = $signed({8'd0, ld_s1, 15'd0});
		num = ghx + glx + (dneg_s1 ? -ldx : ldx);

		nneg = 87'(-num_s2);
		nd   = mag_s3 + 86'({lamp_s3, 14'd0});
		ovf  = {10'd0, nd[85:63]} >= lamp_s3;

		for (int i = 1; i <= QB; i++) begin
			dbl[i]  = {rem_sd[i-1], low_sd[i-1][QB-1]};
			diff[i] = {1'b0, dbl[i]} - {2'b0, den_sd[i-1]};
		end

		limit = neg_sd[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
		qmag  = (ovf_sd[QB] || quo_sd[QB] > limit) ? limit : quo_sd[QB];
		res   = neg_sd[QB] ? -qmag : qmag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_sd <= '0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_sd <= {vld_sd[QB-1:0], vld_s3};
			vld_s5 <= vld_sd[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= tag_in;
			gl_s1   <= in_g * $signed({1'b0, in_smp.prod[31:0]});
			gh_s1   <= in_g * $signed({1'b0, in_smp.prod[63:32]});
			ld_s1   <= blend * dmag;
			dneg_s1 <= in_smp.dot[31];
			lamp_s1 <= {1'b0, blend} + 33'd65536;

			tag_s2  <= tag_s1;
			num_s2  <= num;
			lamp_s2 <= lamp_s1;

			tag_s3  <= tag_s2;
			neg_s3  <= num_s2[86];
			mag_s3  <= num_s2[86] ? nneg[85:0] : num_s2[85:0];
			lamp_s3 <= lamp_s2;

			rem_sd[0] <= ovf ? '0 : QB'(nd[85:QB]);
			low_sd[0] <= nd[QB-1:0];
			quo_sd[0] <= '0;
			den_sd[0] <= {lamp_s3, 15'd0};
			neg_sd[0] <= neg_s3;
			ovf_sd[0] <= ovf;
			tag_sd[0] <= tag_s3;
			for (int i = 1; i <= QB; i++) begin
				rem_sd[i] <= diff[i][QB+1] ? dbl[i][QB-1:0] : diff[i][QB-1:0];
				low_sd[i] <= {low_sd[i-1][QB-2:0], 1'b0};
				quo_sd[i] <= {quo_sd[i-1][QB-2:0], !diff[i][QB+1]};
				den_sd[i] <= den_sd[i-1];
				neg_sd[i] <= neg_sd[i-1];
				ovf_sd[i] <= ovf_sd[i-1];
				tag_sd[i] <= tag_sd[i-1];
			end

			degen_s5 <= tag_sd[QB].degen;
			logit_s5 <= tag_sd[QB].degen ? LOGIT_W'(tag_sd[QB].dot) : $signed(res);
			k_s5     <= tag_sd[QB].degen ? 3'd0 : tag_sd[QB].k;
			cm_s5    <= tag_sd[QB].degen ? 17'sd0 : tag_sd[QB].cm;
		end
	end

	assign out_vld   = vld_s5;
	assign out_logit = logit_s5;
	assign out_k     = k_s5;
	assign out_cm    = cm_s5;
	assign out_degen = degen_s5;

endmodule

// ===== hw/rtl/large_margin_logit_forward.sv =====
// Large-margin softmax target logit, forward path. Each transfer on the s_ side carries one
// sample's dot product and its two norms; the block returns the blended large-margin logit,
// the angle sector, cos(m*theta) and a flag for a zero norm product (the dot is then passed
// through). One sample is taken every cycle while no stall on m_tready holds the output; most
// of the pipeline is the two bit-per-stage dividers (15 stages for the cosine, 48 for the
// final quotient). A stall on m_tready holds the whole pipeline.
// Registers are written through the cfg_ port and must only change while the block is empty.
module large_margin_logit_forward
	import lmlf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // dot_product, sample_norm, weight_norm
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // margin_logit, sector_index, cos_multiple
	output logic [0:0]  m_tuser,   // degenerate_flag
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	logic en;

	logic               vld_s1, vld_s2;
	logic signed [31:0] dot_s1;
	logic [31:0]        sn_s1, wn_s1;
	smp_t               smp_s2;

	logic               cd_vld;
	smp_t               cd_smp;
	logic signed [16:0] cd_cos;
	logic               cm_vld;
	smp_t               cm_smp;
	logic [2:0]         cm_k;
	logic signed [16:0] cm_cm;
	logic signed [19:0] cm_g;

	logic                      o_vld;
	logic signed [LOGIT_W-1:0] o_logit;
	logic [2:0]                o_k;
	logic signed [16:0]        o_cm;
	logic                      o_degen;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.margin   <= 3'd4;
			cfg_q.blend    <= 32'd0;
			cfg_q.bound[0] <= 16'd23170;
			cfg_q.bound[1] <= 16'd0;
			cfg_q.bound[2] <= 16'hA57E;
			cfg_q.bound[3] <= 16'h8000;
			cfg_q.binom2   <= 8'd6;
			cfg_q.binom4   <= 8'd1;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MARGIN: cfg_q.margin   <= cfg_data[2:0];
				REG_BLEND:  cfg_q.blend    <= cfg_data;
				REG_BOUND1: cfg_q.bound[0] <= cfg_data[15:0];
				REG_BOUND2: cfg_q.bound[1] <= cfg_data[15:0];
				REG_BOUND3: cfg_q.bound[2] <= cfg_data[15:0];
				REG_BOUND4: cfg_q.bound[3] <= cfg_data[15:0];
				REG_BINOM2: cfg_q.binom2   <= cfg_data[7:0];
				REG_BINOM4: cfg_q.binom4   <= cfg_data[7:0];
				default:    cfg_q.binom4   <= cfg_q.binom4;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s1       <= $signed(s_tdata[31:0]);
			sn_s1        <= s_tdata[63:32];
			wn_s1        <= s_tdata[95:64];
			smp_s2.dot   <= dot_s1;
			smp_s2.prod  <= sn_s1 * wn_s1;
			smp_s2.degen <= (sn_s1 == 32'd0) || (wn_s1 == 32'd0);
		end
	end

	lmlf_cos_div u_cos_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.in_smp  (smp_s2),
		.out_vld (cd_vld),
		.out_smp (cd_smp),
		.out_cos (cd_cos)
	);

	lmlf_cos_mult u_cos_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg_q),
		.in_vld  (cd_vld),
		.in_smp  (cd_smp),
		.in_cos  (cd_cos),
		.out_vld (cm_vld),
		.out_smp (cm_smp),
		.out_k   (cm_k),
		.out_cm  (cm_cm),
		.out_g   (cm_g)
	);

	lmlf_logit_div u_logit_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.blend     (cfg_q.blend),
		.in_vld    (cm_vld),
		.in_smp    (cm_smp),
		.in_k      (cm_k),
		.in_cm     (cm_cm),
		.in_g      (cm_g),
		.out_vld   (o_vld),
		.out_logit (o_logit),
		.out_k     (o_k),
		.out_cm    (o_cm),
		.out_degen (o_degen)
	);

	assign m_tvalid = o_vld;
	assign m_tdata  = {4'd0, o_cm, o_k, o_logit};
	assign m_tuser  = o_degen;

	// zero norm product gives no sector and no cosine
	a_degen_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[50:48] == 3'd0 && m_tdata[67:51] == 17'd0)
		else $error("degenerate result with nonzero sector or cosine");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[50:48] <= 3'(MARGIN_CAP))
		else $error("sector index beyond margin");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[67:51]) >= -17'sd32768 &&
			$signed(m_tdata[67:51]) <= 17'sd32768)
		else $error("cos_multiple out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

endmodule
